FILE: rtl/core/rrtm_pkg.sv
package rrtm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W   = 31;
  localparam int KIND_W = 8;
  localparam int HGT_W  = 31;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int RCNT_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic [KIND_W-1:0]       kind;
    logic [HGT_W-1:0]        rng_start;
    logic [HGT_W-1:0]        rng_end;
    logic signed [VAL_W-1:0] value;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef struct packed {
    logic             op;
    rule_t            rule;
    logic [HGT_W-1:0] height;
  } req_t;

  typedef struct packed {
    logic dup;
    logic hit;
    logic better;
  } cmp_t;

endpackage

FILE: rtl/core/rrtm_ram.sv
module rrtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/rrtm_cmp.sv
module rrtm_cmp (
  input  rrtm_pkg::req_t              req,
  input  rrtm_pkg::rule_t             entry,
  input  logic                        entry_vld,
  input  logic                        best_found,
  input  logic [rrtm_pkg::ID_W-1:0]   best_id,
  output rrtm_pkg::cmp_t              res
);
  import rrtm_pkg::*;

  logic above_start;
  logic below_end;

  always_comb begin
    above_start = (req.height >= entry.rng_start);
    // An end height of zero leaves the rule open upward.
    below_end   = (entry.rng_end == '0) || (req.height <= entry.rng_end);
    res.dup     = entry_vld && (entry.id == req.rule.id);
    res.hit     = entry_vld && (entry.kind == req.rule.kind) && above_start && below_end;
    res.better  = res.hit && (!best_found || (entry.id > best_id));
  end

endmodule

FILE: rtl/core/range_rule_table_match_core.sv
// Rule table with range lookup. Each item is either an insert or a lookup and
// produces exactly one result. The table is held in a single-port-read RAM and
// all decisions go through one shared compare unit that examines one entry per
// cycle. Each item is accepted, then the whole RAM is streamed through the
// compare unit, and then the result is committed and presented; the next item
// cannot be accepted before the sequencer has finished with the last one.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register and does not block the next item from starting,
// although that item waits at its commit step for as long as the earlier
// result has not been taken.
// Inserts take the lowest free slot; duplicate IDs are reported before a full
// table. Lookups return the covering rule of the requested kind with the
// highest ID.
module range_rule_table_match_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [rrtm_pkg::ID_W-1:0]         in_rule_id,
  input  logic [rrtm_pkg::KIND_W-1:0]       in_rule_kind,
  input  logic [rrtm_pkg::HGT_W-1:0]        in_range_start,
  input  logic [rrtm_pkg::HGT_W-1:0]        in_range_end,
  input  logic signed [rrtm_pkg::VAL_W-1:0] in_rule_value,
  input  logic [rrtm_pkg::HGT_W-1:0]        in_query_height,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rrtm_pkg::STAT_W-1:0]       out_status,
  output logic [rrtm_pkg::ID_W-1:0]         out_match_id,
  output logic signed [rrtm_pkg::VAL_W-1:0] out_match_value,
  output logic [rrtm_pkg::HGT_W-1:0]        out_match_start,
  output logic [rrtm_pkg::HGT_W-1:0]        out_match_end,
  output logic [rrtm_pkg::RCNT_W-1:0]       out_rule_count
);
  import rrtm_pkg::*;

  state_t                  state_r, state_nxt;
  req_t                    req_r, req_nxt;
  logic [IDX_W:0]          cnt_r, cnt_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]        chk_idx_r, chk_idx_nxt;
  logic [TABLE_DEPTH-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]        held_r, held_nxt;
  logic                    dup_r, dup_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [IDX_W-1:0]        free_idx_r, free_idx_nxt;
  logic                    best_found_r, best_found_nxt;
  rule_t                   best_r, best_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  rule_t                   out_rule_r, out_rule_nxt;
  logic [RCNT_W-1:0]       out_count_r, out_count_nxt;

  logic                    accept;
  logic                    done_issue;
  logic                    rd_en;
  logic                    ram_we;
  logic                    out_load;
  logic [RULE_W-1:0]       rd_raw;
  rule_t                   rd_entry;
  logic                    entry_vld;
  cmp_t                    cmp;

  assign accept     = in_valid && in_ready;
  assign done_issue = (cnt_r == (IDX_W+1)'(TABLE_DEPTH));
  assign rd_entry   = rule_t'(rd_raw);
  assign entry_vld  = valid_r[chk_idx_r];

  rrtm_ram #(
    .WIDTH (RULE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (req_r.rule),
    .re    (rd_en),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (rd_raw)
  );

  rrtm_cmp u_cmp (
    .req        (req_r),
    .entry      (rd_entry),
    .entry_vld  (entry_vld),
    .best_found (best_found_r),
    .best_id    (best_r.id),
    .res        (cmp)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (done_issue) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = (state_r == S_IDLE);
    rd_en    = (state_r == S_SCAN) && !done_issue;
    out_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);
    ram_we   = out_load && (req_r.op == OP_INSERT) && !dup_r && free_found_r;
  end

  // Scan datapath: RAM data for entry chk_idx_r arrives in the cycle after its read.
  always_comb begin
    req_nxt        = req_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    dup_nxt        = dup_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;

    if (accept) begin
      req_nxt.op             = in_operation;
      req_nxt.rule.id        = in_rule_id;
      req_nxt.rule.kind      = in_rule_kind;
      req_nxt.rule.rng_start = in_range_start;
      req_nxt.rule.rng_end   = in_range_end;
      req_nxt.rule.value     = in_rule_value;
      req_nxt.height         = in_query_height;
      cnt_nxt                = '0;
      chk_vld_nxt            = 1'b0;
      dup_nxt                = 1'b0;
      free_found_nxt         = 1'b0;
      best_found_nxt         = 1'b0;
    end else if (state_r == S_SCAN) begin
      cnt_nxt     = cnt_r + (IDX_W+1)'(rd_en);
      chk_vld_nxt = rd_en;
      chk_idx_nxt = cnt_r[IDX_W-1:0];
      if (chk_vld_r) begin
        if (cmp.dup) begin
          dup_nxt = 1'b1;
        end
        if (!entry_vld && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_idx_r;
        end
        if ((req_r.op == OP_LOOKUP) && cmp.better) begin
          best_found_nxt = 1'b1;
          best_nxt       = rd_entry;
        end
      end
    end
  end

  // Commit and result.
  always_comb begin
    valid_nxt      = valid_r;
    held_nxt       = held_r + CNT_W'(ram_we);
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rule_nxt   = out_rule_r;
    out_count_nxt  = out_count_r;

    if (ram_we) begin
      valid_nxt[free_idx_r] = 1'b1;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = RCNT_W'(held_nxt);
      out_rule_nxt  = '0;
      if (req_r.op == OP_INSERT) begin
        priority if (dup_r) begin
          out_status_nxt = ST_DUP;
        end else if (!free_found_r) begin
          out_status_nxt = ST_FULL;
        end else begin
          out_status_nxt = ST_INSERTED;
        end
      end else if (best_found_r) begin
        out_status_nxt        = ST_FOUND;
        out_rule_nxt.id        = best_r.id;
        out_rule_nxt.value     = best_r.value;
        out_rule_nxt.rng_start = best_r.rng_start;
        out_rule_nxt.rng_end   = best_r.rng_end;
      end else begin
        out_status_nxt = ST_NONE;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    cnt_r        <= cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    dup_r        <= dup_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    best_found_r <= best_found_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_rule_r   <= out_rule_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_id    = out_rule_r.id;
  assign out_match_value = out_rule_r.value;
  assign out_match_start = out_rule_r.rng_start;
  assign out_match_end   = out_rule_r.rng_end;
  assign out_rule_count  = out_count_r;

endmodule

FILE: rtl/core/rrtm_checker.sv
module rrtm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rrtm_pkg::STAT_W-1:0]       out_status,
  input logic [rrtm_pkg::ID_W-1:0]         out_match_id,
  input logic signed [rrtm_pkg::VAL_W-1:0] out_match_value,
  input logic [rrtm_pkg::HGT_W-1:0]        out_match_start,
  input logic [rrtm_pkg::HGT_W-1:0]        out_match_end,
  input logic [rrtm_pkg::RCNT_W-1:0]       out_rule_count
);
  import rrtm_pkg::*;

  // The sequencer is busy for the whole scan after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an item was taken");

  // A result that has not been taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
      $stable(out_match_id) && $stable(out_rule_count)))
    else $error("pending result changed before it was taken");

  // Only a found lookup carries rule fields.
  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_FOUND)) |->
      ((out_match_id == '0) && (out_match_value == '0) &&
       (out_match_start == '0) && (out_match_end == '0)))
    else $error("rule fields set on a result without a match");

  // A stored rule is reported only by an insert, and it raises the count.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_INSERTED)) |-> (out_rule_count != '0))
    else $error("insert reported with an empty table");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind range_rule_table_match_core rrtm_checker u_rrtm_checker (.*);

FILE: bench/range_rule_table_match_core_tb.sv
`timescale 1ns / 1ps

module range_rule_table_match_core_tb;
  import rrtm_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    status_t                 status;
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] value;
    logic [HGT_W-1:0]        rng_start;
    logic [HGT_W-1:0]        rng_end;
    logic [RCNT_W-1:0]       count;
  } outcome_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_operation = OP_INSERT;
  logic [ID_W-1:0]         in_rule_id = '0;
  logic [KIND_W-1:0]       in_rule_kind = '0;
  logic [HGT_W-1:0]        in_range_start = '0;
  logic [HGT_W-1:0]        in_range_end = '0;
  logic signed [VAL_W-1:0] in_rule_value = '0;
  logic [HGT_W-1:0]        in_query_height = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic [ID_W-1:0]         out_match_id;
  logic signed [VAL_W-1:0] out_match_value;
  logic [HGT_W-1:0]        out_match_start;
  logic [HGT_W-1:0]        out_match_end;
  logic [RCNT_W-1:0]       out_rule_count;

  // Our own copy of the rule table, updated in the order items are accepted.
  rule_t       copy_rule [TABLE_DEPTH];
  bit          copy_used [TABLE_DEPTH];
  int unsigned copy_count = 0;

  outcome_t    awaited_outcomes[$];
  int          error_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  range_rule_table_match_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_rule_id      (in_rule_id),
    .in_rule_kind    (in_rule_kind),
    .in_range_start  (in_range_start),
    .in_range_end    (in_range_end),
    .in_rule_value   (in_rule_value),
    .in_query_height (in_query_height),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_match_id    (out_match_id),
    .out_match_value (out_match_value),
    .out_match_start (out_match_start),
    .out_match_end   (out_match_end),
    .out_rule_count  (out_rule_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic outcome_t apply_to_rule_copy(input req_t r);
    outcome_t res;
    int       free_slot;
    int       best;
    bit       dup;
    res = '0;
    free_slot = -1;
    best = -1;
    dup = 1'b0;
    if (r.op == OP_INSERT) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (copy_used[i]) begin
          if (copy_rule[i].id == r.rule.id) dup = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      // A held ID is reported as a duplicate even when the table is full.
      if (dup) begin
        res.status = ST_DUP;
      end else if (free_slot < 0) begin
        res.status = ST_FULL;
      end else begin
        copy_used[free_slot] = 1'b1;
        copy_rule[free_slot] = r.rule;
        copy_count++;
        res.status = ST_INSERTED;
      end
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!copy_used[i] || copy_rule[i].kind != r.rule.kind) continue;
        if (r.height < copy_rule[i].rng_start) continue;
        if (copy_rule[i].rng_end != '0 && r.height > copy_rule[i].rng_end) continue;
        if (best < 0 || copy_rule[i].id > copy_rule[best].id) best = i;
      end
      if (best >= 0) begin
        res.status    = ST_FOUND;
        res.id        = copy_rule[best].id;
        res.value     = copy_rule[best].value;
        res.rng_start = copy_rule[best].rng_start;
        res.rng_end   = copy_rule[best].rng_end;
      end else begin
        res.status = ST_NONE;
      end
    end
    res.count = copy_count[RCNT_W-1:0];
    return res;
  endfunction

  function automatic string describe_outcome(input outcome_t o);
    return $sformatf("status %0d id %h value %h start %h end %h count %0d",
                     o.status, o.id, o.value, o.rng_start, o.rng_end, o.count);
  endfunction

  // Fields that the operation does not use are filled with random values.
  function automatic req_t make_insert(input logic [ID_W-1:0] id,
                                       input logic [KIND_W-1:0] kind,
                                       input logic [HGT_W-1:0] rng_start,
                                       input logic [HGT_W-1:0] rng_end,
                                       input logic signed [VAL_W-1:0] value);
    req_t r;
    r.op             = OP_INSERT;
    r.rule.id        = id;
    r.rule.kind      = kind;
    r.rule.rng_start = rng_start;
    r.rule.rng_end   = rng_end;
    r.rule.value     = value;
    r.height         = HGT_W'($urandom);
    return r;
  endfunction

  function automatic req_t make_lookup(input logic [KIND_W-1:0] kind,
                                       input logic [HGT_W-1:0] height);
    req_t r;
    r.op             = OP_LOOKUP;
    r.rule.id        = ID_W'($urandom);
    r.rule.kind      = kind;
    r.rule.rng_start = HGT_W'($urandom);
    r.rule.rng_end   = HGT_W'($urandom);
    r.rule.value     = $urandom;
    r.height         = height;
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] random_kind();
    case ($urandom_range(9))
      7:       return 8'hFF;
      8:       return 8'h80;
      9:       return KIND_W'($urandom);
      default: return KIND_W'($urandom_range(3));
    endcase
  endfunction

  // Rules use few kinds and clustered heights so that lookups often see
  // several candidates; most lookups aim at held ranges and their edges.
  function automatic req_t random_request();
    req_t  r;
    rule_t aim;
    int    insert_pct;
    r = make_lookup(KIND_W'($urandom), HGT_W'($urandom));
    insert_pct = (copy_count < TABLE_DEPTH) ? 45 : 25;
    if ($urandom_range(99) < insert_pct) begin
      r.op = OP_INSERT;
      if (copy_count > 0 && $urandom_range(99) < 30) begin
        r.rule.id = copy_rule[$urandom_range(copy_count - 1)].id;
      end else if ($urandom_range(1) == 0) begin
        r.rule.id = ID_W'($urandom_range(64));
      end
      r.rule.kind = random_kind();
      case ($urandom_range(2))
        0: r.rule.rng_start = '0;
        1: r.rule.rng_start = HGT_W'($urandom_range(1000));
        default: ;
      endcase
      case ($urandom_range(3))
        0: r.rule.rng_end = '0;
        1: r.rule.rng_end = HGT_W'(r.rule.rng_start + $urandom_range(500));
        2: r.rule.rng_end = HGT_W'($urandom_range(1000));
        default: ;
      endcase
    end else if (copy_count > 0 && $urandom_range(99) < 80) begin
      aim = copy_rule[$urandom_range(copy_count - 1)];
      r.rule.kind = aim.kind;
      case ($urandom_range(6))
        0: r.height = aim.rng_start - 1'b1;
        1: r.height = aim.rng_start;
        2: r.height = aim.rng_start + 1'b1;
        3: r.height = aim.rng_end - 1'b1;
        4: r.height = aim.rng_end;
        5: r.height = aim.rng_end + 1'b1;
        default: r.height = HGT_W'(aim.rng_start + $urandom_range(200));
      endcase
    end else begin
      r.rule.kind = random_kind();
      if ($urandom_range(1) == 0) r.height = HGT_W'($urandom_range(1500));
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_operation    <= r.op;
    in_rule_id      <= r.rule.id;
    in_rule_kind    <= r.rule.kind;
    in_range_start  <= r.rule.rng_start;
    in_range_end    <= r.rule.rng_end;
    in_rule_value   <= r.rule.value;
    in_query_height <= r.height;
    do @(posedge clk); while (!in_ready);
    awaited_outcomes = {awaited_outcomes, apply_to_rule_copy(r)};
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table_lookup();
    send_request(make_lookup(8'h00, '0));
    send_request(make_lookup(8'hFF, '1));
  endtask

  task automatic test_insert_and_duplicate();
    send_request(make_insert(31'd5, 8'h03, 31'd100, 31'd200, -32'sd1));
    send_request(make_insert(31'd5, 8'h07, '0, '0, 32'sd1234));
  endtask

  task automatic test_range_edges();
    send_request(make_lookup(8'h03, 31'd99));
    send_request(make_lookup(8'h03, 31'd100));
    send_request(make_lookup(8'h03, 31'd200));
    send_request(make_lookup(8'h03, 31'd201));
  endtask

  task automatic test_highest_id_wins();
    send_request(make_insert('1, 8'h03, 31'd150, '0, 32'sh8000_0000));
    send_request(make_lookup(8'h03, 31'd150));
    send_request(make_lookup(8'h03, '1));
    send_request(make_lookup(8'h03, 31'd120));
    send_request(make_lookup(8'h04, 31'd150));
  endtask

  task automatic test_field_extremes();
    send_request(make_insert('0, 8'hFF, '0, '1, 32'sh7FFF_FFFF));
    send_request(make_lookup(8'hFF, '0));
    send_request(make_lookup(8'hFF, '1));
    // A rule whose end lies below its start covers no height at all.
    send_request(make_insert(31'd9, 8'h80, 31'd300, 31'd250, 32'sd77));
    send_request(make_lookup(8'h80, 31'd275));
    send_request(make_lookup(8'h80, 31'd300));
  endtask

  task automatic test_full_table();
    req_t            r;
    logic [ID_W-1:0] fresh_id;
    bit              taken;
    while (copy_count < TABLE_DEPTH) begin
      r = random_request();
      r.op = OP_INSERT;
      send_request(r);
    end
    wait_for_results();
    do begin
      fresh_id = ID_W'($urandom);
      taken = 1'b0;
      foreach (copy_rule[i]) if (copy_rule[i].id == fresh_id) taken = 1'b1;
    end while (taken);
    send_request(make_insert(fresh_id, random_kind(), HGT_W'($urandom),
                             HGT_W'($urandom), $urandom));
    send_request(make_insert(copy_rule[0].id, 8'h11, '0, '0, 32'sd5));
    send_request(make_lookup(copy_rule[TABLE_DEPTH-1].kind,
                             copy_rule[TABLE_DEPTH-1].rng_start));
  endtask

  task automatic run_random_phase(input int items, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) begin
      if ($urandom_range(99) == 0) wait_for_results();
      send_request(random_request());
    end
  endtask

  always @(posedge clk) begin
    if (recv_stall_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    outcome_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status    = status_t'(out_status);
      got.id        = out_match_id;
      got.value     = out_match_value;
      got.rng_start = out_match_start;
      got.rng_end   = out_match_end;
      got.count     = out_rule_count;
      if (awaited_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result with no item outstanding: %s", $time, describe_outcome(got));
      end else begin
        want = awaited_outcomes.pop_front();
        if (got.status !== want.status || got.id !== want.id || got.value !== want.value ||
            got.rng_start !== want.rng_start || got.rng_end !== want.rng_end ||
            got.count !== want.count) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: mismatch, expected %s", $time, describe_outcome(want));
            $display("%0t:           got      %s", $time, describe_outcome(got));
          end
        end
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table_lookup();
    test_insert_and_duplicate();
    test_range_edges();
    test_highest_id_wins();
    test_field_extremes();
    run_random_phase(460, 0, 0);
    test_full_table();
    run_random_phase(460, 50, 0);
    run_random_phase(460, 0, 50);
    run_random_phase(460, 27, 27);
    wait_for_results();
    repeat (2 * (TABLE_DEPTH + 3)) @(posedge clk);
    if (error_count == 0 && awaited_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
